[rtl/brpr_pkg.sv]
// Package for the byte ring buffer with peek and remove.
// Holds command and status codes, field widths and the result record type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brpr_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int DEPTH_DEFAULT    = 4096;
  localparam int MAX_PEEK_DEFAULT = 64;

  // Fixed field widths.
  localparam int CNT_W   = 13;           // count, capacity, fill level
  localparam int OFS_W   = 12;           // peek offset
  localparam int SUM_W   = CNT_W + 1;    // index sums before the wrap
  localparam int BYTE_W  = 8;
  localparam int CAP_RST = 4096;         // capacity after reset, before clamping

  // Commands.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_PEEK   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // Register index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] read_byte;
    logic              last;
    logic [CNT_W-1:0]  fill_level;
    logic              is_full;
  } res_t;

endpackage

`default_nettype wire

[rtl/brpr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the byte store of the ring buffer.
`timescale 1ns / 1ps
`default_nettype none

module brpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/byte_ring_buffer_peek_remove_core.sv]
// Byte ring buffer with append bursts, peek, remove and clear.
// A result beat passes the issue stage register, then the output queue, before it is offered.
// Append, remove, clear and every single-result peek are done as their beat is accepted;
// a peek of n bytes stalls input, reading one store byte per cycle while the queue has room.
// Reset clears indices, fill count and burst state at once; the byte store is not cleared.
// Depends on brpr_pkg and brpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_peek_remove_core #(
  parameter int DEPTH    = brpr_pkg::DEPTH_DEFAULT,
  parameter int MAX_PEEK = brpr_pkg::MAX_PEEK_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [brpr_pkg::BYTE_W-1:0]  data_byte_i,
  input  wire logic                         first_of_burst_i,
  input  wire logic [brpr_pkg::CNT_W-1:0]   count_i,
  input  wire logic [brpr_pkg::OFS_W-1:0]   peek_offset_i,
  // Result channel.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        status_o,
  output logic [brpr_pkg::BYTE_W-1:0]       read_byte_o,
  output logic                              last_o,
  output logic [brpr_pkg::CNT_W-1:0]        fill_level_o,
  output logic                              is_full_o,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  // Address width of the byte store, and the width of ring indices. An index is
  // always below the capacity, which never exceeds DEPTH nor the 13-bit field range.
  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = (AW > brpr_pkg::CNT_W) ? brpr_pkg::CNT_W : AW;
  localparam int CAP_MAX = (DEPTH > 8191) ? 8191 : DEPTH;
  localparam int CAP_R   = (brpr_pkg::CAP_RST > CAP_MAX) ? CAP_MAX : brpr_pkg::CAP_RST;
  localparam int PCW     = $clog2(MAX_PEEK + 1);

  localparam int CW = brpr_pkg::CNT_W;
  localparam int SW = brpr_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Architectural state.
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  cap_q, cap_d;          // effective capacity, clamped
  logic [CW-1:0]  cap_raw_q, cap_raw_d;  // value as written, for readback
  logic [IW-1:0]  wi_q, wi_d;            // write index
  logic [IW-1:0]  ri_q, ri_d;            // read index (oldest byte)
  logic [CW-1:0]  stored_q, stored_d;    // fill level
  logic           refused_q, refused_d;  // current burst was refused
  logic [CW-1:0]  owed_q, owed_d;        // bytes still owed to the accepted burst

  // Peek sequencer: remaining reads and the ring position of the next one.
  logic [PCW-1:0] pk_left_q, pk_left_d;
  logic [IW-1:0]  pk_pos_q, pk_pos_d;
  logic           pk_busy;

  // Issue stage: while the queue has credit, one result per cycle enters here while the store read is in
  // flight; the next cycle it joins the output queue with the read data.
  logic                 pend_valid_q;
  brpr_pkg::res_t       pend_res_q;
  logic                 pend_ram_q;
  logic                 iss_valid;
  brpr_pkg::res_t       iss_res;
  logic                 iss_ram;
  brpr_pkg::res_t       push_res;

  // Two-entry output queue decouples the result side from the store pipeline.
  brpr_pkg::res_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;
  logic [1:0]     occ;
  logic           credit;

  // Byte store.
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [brpr_pkg::BYTE_W-1:0]  ram_rdata;

  logic           in_accept;
  logic           cfg_we;
  logic [CW-1:0]  cfg_val;
  logic [SW-1:0]  sum;
  logic [SW-1:0]  room_chk;
  logic [IW-1:0]  pos_first;
  logic [IW-1:0]  pos_issue;

  // Wrap a sum that is known to stay below twice the capacity.
  function automatic logic [SW-1:0] wrap_cap(logic [SW-1:0] s, logic [CW-1:0] cap);
    logic [SW-1:0] c;
    c = {1'b0, cap};
    return (s >= c) ? (s - c) : s;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshakes.
  // ---------------------------------------------------------------------------
  assign pop    = (cnt_q != 2'd0) && !out_stall_i;
  assign push   = pend_valid_q;
  assign occ    = cnt_q + {1'b0, pend_valid_q};
  // A new result may issue if the queue, counting the beat in flight, still has
  // a free entry after this cycle's pop.
  assign credit = (occ - {1'b0, pop}) < 2'd2;

  assign pk_busy    = (pk_left_q != '0);
  assign in_stall_o = pk_busy || !credit;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_val = pwdata[CW-1:0];
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == brpr_pkg::REG_CAPACITY) ? 32'(cap_raw_q) : 32'd0;

  // ---------------------------------------------------------------------------
  // Command decode and state update.
  // ---------------------------------------------------------------------------
  always_comb begin
    cap_d     = cap_q;
    cap_raw_d = cap_raw_q;
    wi_d      = wi_q;
    ri_d      = ri_q;
    stored_d  = stored_q;
    refused_d = refused_q;
    owed_d    = owed_q;
    pk_left_d = pk_left_q;
    pk_pos_d  = pk_pos_q;

    ram_we    = 1'b0;
    ram_waddr = AW'(wi_q);
    ram_re    = 1'b0;
    ram_raddr = AW'(pk_pos_q);

    iss_valid = 1'b0;
    iss_res   = '0;
    iss_ram   = 1'b0;

    sum       = '0;
    room_chk  = '0;
    pos_first = '0;
    pos_issue = '0;

    // A capacity write also empties the store and ends any burst.
    if (cfg_we && (paddr[2] == brpr_pkg::REG_CAPACITY)) begin
      cap_raw_d = cfg_val;
      if (cfg_val == '0) begin
        cap_d = CW'(1);
      end else if (int'(cfg_val) > CAP_MAX) begin
        cap_d = CW'(CAP_MAX);
      end else begin
        cap_d = cfg_val;
      end
      wi_d      = '0;
      ri_d      = '0;
      stored_d  = '0;
      refused_d = 1'b0;
      owed_d    = '0;
    end

    if (in_accept) begin
      iss_valid      = 1'b1;
      iss_res.status = brpr_pkg::ST_OK;
      iss_res.last   = 1'b1;
      unique case (cmd_i)
        brpr_pkg::CMD_APPEND: begin
          // A first byte either opens a burst or refuses the whole of it.
          if (first_of_burst_i) begin
            if (count_i > (cap_q - stored_q)) begin
              refused_d = 1'b1;
              owed_d    = '0;
            end else begin
              refused_d = 1'b0;
              owed_d    = count_i;
            end
          end
          if (refused_d) begin
            iss_res.status = brpr_pkg::ST_NO_ROOM;
          end else if ((owed_d != '0) || (stored_q < cap_q)) begin
            if (owed_d != '0) begin
              owed_d = owed_d - CW'(1);
            end
            ram_we   = 1'b1;
            sum      = SW'(wi_q) + SW'(1);
            wi_d     = (sum >= {1'b0, cap_q}) ? '0 : IW'(sum);
            stored_d = stored_q + CW'(1);
          end else begin
            iss_res.status = brpr_pkg::ST_NO_ROOM;
          end
        end
        brpr_pkg::CMD_PEEK: begin
          room_chk = SW'(peek_offset_i) + SW'(count_i);
          if (count_i > CW'(MAX_PEEK)) begin
            iss_res.status = brpr_pkg::ST_TOO_LONG;
          end else if (room_chk > {1'b0, stored_q}) begin
            iss_res.status = brpr_pkg::ST_SHORT;
          end else if (count_i != '0) begin
            // First byte is read now, the rest by the sequencer.
            pos_first    = IW'(wrap_cap(SW'(ri_q) + SW'(peek_offset_i), cap_q));
            ram_re       = 1'b1;
            ram_raddr    = AW'(pos_first);
            iss_ram      = 1'b1;
            iss_res.last = (count_i == CW'(1));
            pk_left_d    = PCW'(count_i - CW'(1));
            pk_pos_d     = IW'(wrap_cap(SW'(pos_first) + SW'(1), cap_q));
          end
        end
        brpr_pkg::CMD_REMOVE: begin
          if (count_i > stored_q) begin
            iss_res.status = brpr_pkg::ST_SHORT;
          end else begin
            ri_d     = IW'(wrap_cap(SW'(ri_q) + SW'(count_i), cap_q));
            stored_d = stored_q - count_i;
          end
        end
        brpr_pkg::CMD_CLEAR: begin
          wi_d      = '0;
          ri_d      = '0;
          stored_d  = '0;
          refused_d = 1'b0;
          owed_d    = '0;
        end
        default: begin
        end
      endcase
    end else if (pk_busy && credit) begin
      pos_issue    = pk_pos_q;
      ram_re       = 1'b1;
      ram_raddr    = AW'(pos_issue);
      iss_valid    = 1'b1;
      iss_ram      = 1'b1;
      iss_res.last = (pk_left_q == PCW'(1));
      pk_left_d    = pk_left_q - PCW'(1);
      pk_pos_d     = IW'(wrap_cap(SW'(pk_pos_q) + SW'(1), cap_q));
    end

    // Every result reports the fill level after its step.
    iss_res.fill_level = stored_d;
    iss_res.is_full    = (stored_d == cap_q);
  end

  // The beat in flight picks up its byte from the store read as it enters the queue.
  always_comb begin
    push_res           = pend_res_q;
    push_res.read_byte = pend_ram_q ? ram_rdata : '0;
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CW'(CAP_R);
      cap_raw_q    <= CW'(brpr_pkg::CAP_RST);
      wi_q         <= '0;
      ri_q         <= '0;
      stored_q     <= '0;
      refused_q    <= 1'b0;
      owed_q       <= '0;
      pk_left_q    <= '0;
      pend_valid_q <= 1'b0;
      wr_ptr_q     <= 1'b0;
      rd_ptr_q     <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      cap_q        <= cap_d;
      cap_raw_q    <= cap_raw_d;
      wi_q         <= wi_d;
      ri_q         <= ri_d;
      stored_q     <= stored_d;
      refused_q    <= refused_d;
      owed_q       <= owed_d;
      pk_left_q    <= pk_left_d;
      pend_valid_q <= iss_valid;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    pk_pos_q <= pk_pos_d;
    if (iss_valid) begin
      pend_res_q <= iss_res;
      pend_ram_q <= iss_ram;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte store.
  // ---------------------------------------------------------------------------
  brpr_ram #(
    .WIDTH (brpr_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result outputs.
  // ---------------------------------------------------------------------------
  assign out_valid_o  = (cnt_q != 2'd0);
  assign status_o     = fifo_q[rd_ptr_q].status;
  assign read_byte_o  = fifo_q[rd_ptr_q].read_byte;
  assign last_o       = fifo_q[rd_ptr_q].last;
  assign fill_level_o = fifo_q[rd_ptr_q].fill_level;
  assign is_full_o    = fifo_q[rd_ptr_q].is_full;

endmodule

`default_nettype wire
